/* rtl/glyph_coverage_blit_top_macros.svh */
// Assertion macros used by the checker of this block.
`ifndef GLYPH_COVERAGE_BLIT_TOP_MACROS_SVH
`define GLYPH_COVERAGE_BLIT_TOP_MACROS_SVH

// Same-cycle implication.
`define GCB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication.
`define GCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

/* rtl/gcb_pkg.sv */
package gcb_pkg;

   localparam int LANES      = 8;
   localparam int LANE_W     = 3;
   localparam int POS_W      = 13;
   localparam int SUM_W      = 14;
   localparam int COL_W      = 11;
   localparam int COORD_W    = 12;
   localparam int BYTE_W     = 8;
   localparam int GW_REG_W   = 9;
   localparam int DIM_REG_W  = 13;
   localparam int FMT_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PIXEL_W    = 32;

   localparam int DEF_MAX_GLYPH_DIM   = 256;
   localparam int DEF_MAX_SURFACE_DIM = 4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X        = 3'd0,
      CSR_POS_Y        = 3'd1,
      CSR_GLYPH_WIDTH  = 3'd2,
      CSR_DEST_WIDTH   = 3'd3,
      CSR_DEST_HEIGHT  = 3'd4,
      CSR_COLOR_ARGB   = 3'd5,
      CSR_PIXEL_FORMAT = 3'd6,
      CSR_DEST_INDEX8  = 3'd7
   } csr_index_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_GRAY = 2'd0,
      FMT_MONO = 2'd1,
      FMT_NONE = 2'd2
   } format_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [GW_REG_W-1:0]     glyph_width;
      logic [DIM_REG_W-1:0]    dest_width;
      logic [DIM_REG_W-1:0]    dest_height;
      logic [PIXEL_W-1:0]      color_argb;
      logic [FMT_W-1:0]        pixel_format;
      logic                    dest_index8;
   } cfg_type;

   // One item after clipping: surviving lanes, x of lane 0, row, scaled alpha.
   typedef struct packed {
      logic [LANES-1:0]        mask;
      logic signed [SUM_W-1:0] dx0;
      logic [COORD_W-1:0]      dy;
      logic [BYTE_W-1:0]       alpha;
   } work_type;

endpackage

/* rtl/gcb_ifs.sv */
interface gcb_req_if;
   logic                            valid;
   logic                            ready;
   logic [gcb_pkg::BYTE_W-1:0]      src_byte;
   logic [gcb_pkg::BYTE_W-1:0]      glyph_row;
   logic [gcb_pkg::BYTE_W-1:0]      byte_col;

   modport source (output valid, output src_byte, output glyph_row, output byte_col,
                   input ready);
   modport sink (input valid, input src_byte, input glyph_row, input byte_col,
                 output ready);
endinterface

interface gcb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gcb_pkg::COORD_W-1:0]     dest_x;
   logic [gcb_pkg::COORD_W-1:0]     dest_y;
   logic [gcb_pkg::PIXEL_W-1:0]     pixel_value;
   logic                            last;

   modport source (output valid, output dest_x, output dest_y, output pixel_value,
                   output last, input ready);
   modport sink (input valid, input dest_x, input dest_y, input pixel_value,
                 input last, output ready);
endinterface

/* rtl/glyph_coverage_blit_top.sv */
// Glyph coverage blit.
// req_bus carries one byte of a glyph bitmap row (src_byte, glyph_row, byte_col).
// rsp_bus returns the pixels that byte places on the surface, in column order,
// each with dest_x, dest_y and pixel_value; last marks the final pixel of a byte.
// A byte that places no pixel returns nothing. Both channels use valid/ready.
// Registers are written through csr_we/csr_index/csr_wdata, by the user only while
// the block is idle; the block itself does not enforce this. They set position,
// glyph width, surface size, color, format and mode. The first pixel of a byte
// passes the input register, the work register and the result register in turn.
// A gray byte, or a mono byte with at most one visible pixel, gives at most one
// pixel; a mono byte gives one pixel per visible lane, up to eight, and the single
// result register issues one pixel per cycle while rsp_bus is ready. Input
// register, work register and result register are separate, so a new item is
// taken while a result waits. When rsp_bus stalls, the pipeline holds and req_bus
// ready drops once the input register is full. Reset (synchronous) clears the
// configuration registers to zero and empties the pipeline.
module glyph_coverage_blit_top #(
   parameter int MAX_GLYPH_DIM   = gcb_pkg::DEF_MAX_GLYPH_DIM,
   parameter int MAX_SURFACE_DIM = gcb_pkg::DEF_MAX_SURFACE_DIM
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gcb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   gcb_req_if.sink                            req_bus,
   gcb_rsp_if.source                          rsp_bus
);

   gcb_pkg::cfg_type               cfg_ff, cfg_in;

   logic                           a_valid_ff, a_valid_in;
   logic [gcb_pkg::BYTE_W-1:0]     a_src_ff, a_row_ff, a_col_ff;
   gcb_pkg::work_type              a_work;

   gcb_pkg::work_type              b_work_ff, b_work_in;

   logic                           o_valid_ff, o_valid_in;
   logic [gcb_pkg::COORD_W-1:0]    o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic [gcb_pkg::PIXEL_W-1:0]    o_value_ff, o_value_in;
   logic                           o_last_ff, o_last_in;

   logic                           req_accept;
   logic                           out_free;
   logic [gcb_pkg::LANES-1:0]      b_pick, b_rest;
   logic                           b_active, b_emit, b_free, a_move;
   logic [gcb_pkg::LANE_W-1:0]     lane;

   gcb_lanes #(
      .MAX_GLYPH_DIM  (MAX_GLYPH_DIM),
      .MAX_SURFACE_DIM(MAX_SURFACE_DIM)
   ) u_lanes (
      .cfg      (cfg_ff),
      .src_byte (a_src_ff),
      .glyph_row(a_row_ff),
      .byte_col (a_col_ff),
      .work     (a_work)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (gcb_pkg::csr_index_type'(csr_index))
            gcb_pkg::CSR_POS_X: begin
               cfg_in.pos_x = $signed(csr_wdata[gcb_pkg::POS_W-1:0]);
            end
            gcb_pkg::CSR_POS_Y: begin
               cfg_in.pos_y = $signed(csr_wdata[gcb_pkg::POS_W-1:0]);
            end
            gcb_pkg::CSR_GLYPH_WIDTH: begin
               cfg_in.glyph_width = csr_wdata[gcb_pkg::GW_REG_W-1:0];
            end
            gcb_pkg::CSR_DEST_WIDTH: begin
               cfg_in.dest_width = csr_wdata[gcb_pkg::DIM_REG_W-1:0];
            end
            gcb_pkg::CSR_DEST_HEIGHT: begin
               cfg_in.dest_height = csr_wdata[gcb_pkg::DIM_REG_W-1:0];
            end
            gcb_pkg::CSR_COLOR_ARGB: begin
               cfg_in.color_argb = csr_wdata[gcb_pkg::PIXEL_W-1:0];
            end
            gcb_pkg::CSR_PIXEL_FORMAT: begin
               cfg_in.pixel_format = csr_wdata[gcb_pkg::FMT_W-1:0];
            end
            gcb_pkg::CSR_DEST_INDEX8: begin
               cfg_in.dest_index8 = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_free = !o_valid_ff || rsp_bus.ready;
      b_pick   = b_work_ff.mask & (~b_work_ff.mask + gcb_pkg::LANES'(1));
      b_rest   = b_work_ff.mask & ~b_pick;
      b_active = |b_work_ff.mask;
      b_emit   = b_active && out_free;
      b_free   = !b_active || (out_free && (b_rest == '0));
      // an item with no surviving pixel is dropped without waiting
      a_move   = a_valid_ff && (b_free || (a_work.mask == '0));
      req_bus.ready = !a_valid_ff || a_move;
      req_accept    = req_bus.valid && req_bus.ready;

      lane = '0;
      for (int k = gcb_pkg::LANES - 1; k >= 0; k--) begin
         if (b_pick[k]) begin
            lane = gcb_pkg::LANE_W'(k);
         end
      end

      a_valid_in = req_accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

      b_work_in = b_work_ff;
      if (a_valid_ff && b_free) begin
         b_work_in = a_work;
      end else if (b_emit) begin
         b_work_in.mask = b_rest;
      end

      o_valid_in = o_valid_ff;
      o_x_in     = o_x_ff;
      o_y_in     = o_y_ff;
      o_value_in = o_value_ff;
      o_last_in  = o_last_ff;
      if (b_emit) begin
         o_valid_in = 1'b1;
         o_x_in     = gcb_pkg::COORD_W'(b_work_ff.dx0 + $signed(gcb_pkg::SUM_W'(lane)));
         o_y_in     = b_work_ff.dy;
         o_value_in = cfg_ff.dest_index8 ? gcb_pkg::PIXEL_W'(1)
                                         : {b_work_ff.alpha, cfg_ff.color_argb[23:0]};
         o_last_in  = (b_rest == '0);
      end else if (rsp_bus.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_work_ff  <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         a_valid_ff <= a_valid_in;
         b_work_ff  <= b_work_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_src_ff <= req_bus.src_byte;
         a_row_ff <= req_bus.glyph_row;
         a_col_ff <= req_bus.byte_col;
      end
      o_x_ff     <= o_x_in;
      o_y_ff     <= o_y_in;
      o_value_ff <= o_value_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_bus.valid       = o_valid_ff;
   assign rsp_bus.dest_x      = o_x_ff;
   assign rsp_bus.dest_y      = o_y_ff;
   assign rsp_bus.pixel_value = o_value_ff;
   assign rsp_bus.last        = o_last_ff;

endmodule

/* rtl/gcb_lanes.sv */
module gcb_lanes #(
   parameter int MAX_GLYPH_DIM   = gcb_pkg::DEF_MAX_GLYPH_DIM,
   parameter int MAX_SURFACE_DIM = gcb_pkg::DEF_MAX_SURFACE_DIM
) (
   input  gcb_pkg::cfg_type                cfg,
   input  logic [gcb_pkg::BYTE_W-1:0]      src_byte,
   input  logic [gcb_pkg::BYTE_W-1:0]      glyph_row,
   input  logic [gcb_pkg::BYTE_W-1:0]      byte_col,
   output gcb_pkg::work_type               work
);

   localparam int GW_W  = $clog2(MAX_GLYPH_DIM + 1);
   localparam int SW_W  = $clog2(MAX_SURFACE_DIM + 1);
   localparam int CCW   = (GW_W > gcb_pkg::COL_W) ? GW_W : gcb_pkg::COL_W;
   localparam int CMP_W = ((SW_W > gcb_pkg::SUM_W) ? SW_W : gcb_pkg::SUM_W) + 1;

   logic [GW_W-1:0]                  gw_eff;
   logic [SW_W-1:0]                  dw_eff;
   logic [SW_W-1:0]                  dh_eff;
   logic                             is_gray;
   logic                             is_mono;
   logic signed [gcb_pkg::SUM_W-1:0] dy_s;
   logic                             dy_ok;
   logic [gcb_pkg::COL_W-1:0]        first_col;
   logic signed [gcb_pkg::SUM_W-1:0] dx0;
   logic [gcb_pkg::COL_W-1:0]        col_k [gcb_pkg::LANES];
   logic [gcb_pkg::SUM_W-1:0]        dx_k  [gcb_pkg::LANES];
   logic [gcb_pkg::LANES-1:0]        mask;
   logic [gcb_pkg::BYTE_W-1:0]       cov;
   logic [2*gcb_pkg::BYTE_W-1:0]     prod;
   logic [2*gcb_pkg::BYTE_W-1:0]     quot_sum;

   always_comb begin
      gw_eff = (int'(cfg.glyph_width) > MAX_GLYPH_DIM) ? GW_W'(MAX_GLYPH_DIM)
                                                       : GW_W'(cfg.glyph_width);
      dw_eff = (int'(cfg.dest_width) > MAX_SURFACE_DIM) ? SW_W'(MAX_SURFACE_DIM)
                                                        : SW_W'(cfg.dest_width);
      dh_eff = (int'(cfg.dest_height) > MAX_SURFACE_DIM) ? SW_W'(MAX_SURFACE_DIM)
                                                         : SW_W'(cfg.dest_height);
      is_gray = (cfg.pixel_format == gcb_pkg::FMT_GRAY);
      is_mono = (cfg.pixel_format == gcb_pkg::FMT_MONO);

      dy_s  = gcb_pkg::SUM_W'(cfg.pos_y) + $signed(gcb_pkg::SUM_W'(glyph_row));
      dy_ok = !dy_s[gcb_pkg::SUM_W-1] &&
              (CMP_W'(dy_s[gcb_pkg::SUM_W-2:0]) < CMP_W'(dh_eff));

      first_col = is_mono ? {byte_col, 3'b000} : gcb_pkg::COL_W'(byte_col);
      dx0       = gcb_pkg::SUM_W'(cfg.pos_x) + $signed(gcb_pkg::SUM_W'(first_col));

      for (int k = 0; k < gcb_pkg::LANES; k++) begin
         col_k[k] = first_col + gcb_pkg::COL_W'(k);
         dx_k[k]  = gcb_pkg::SUM_W'(dx0) + gcb_pkg::SUM_W'(k);
         mask[k]  = (is_mono ? src_byte[gcb_pkg::LANES-1-k]
                             : (is_gray && (k == 0) && (src_byte != '0))) &&
                    dy_ok &&
                    (CCW'(col_k[k]) < CCW'(gw_eff)) &&
                    !dx_k[k][gcb_pkg::SUM_W-1] &&
                    (CMP_W'(dx_k[k][gcb_pkg::SUM_W-2:0]) < CMP_W'(dw_eff));
      end

      // floor(p/255) for p <= 255*255: (p + (p >> 8) + 1) >> 8
      cov      = is_mono ? {gcb_pkg::BYTE_W{1'b1}} : src_byte;
      prod     = cov * cfg.color_argb[31:24];
      quot_sum = prod + (prod >> 8) + 16'd1;

      work.mask  = mask;
      work.dx0   = dx0;
      work.dy    = gcb_pkg::COORD_W'(dy_s);
      work.alpha = quot_sum[2*gcb_pkg::BYTE_W-1:gcb_pkg::BYTE_W];
   end

endmodule

/* rtl/gcb_checker.sv */
`include "glyph_coverage_blit_top_macros.svh"

module gcb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [gcb_pkg::COORD_W-1:0]       rsp_dest_x,
   input logic [gcb_pkg::COORD_W-1:0]       rsp_dest_y,
   input logic [gcb_pkg::PIXEL_W-1:0]       rsp_pixel_value,
   input logic                              rsp_last
);

   logic                                          req_idle;
   logic [2*gcb_pkg::COORD_W+gcb_pkg::PIXEL_W:0]  rsp_payload;

   assign req_idle    = !req_valid;
   assign rsp_payload = {rsp_dest_x, rsp_dest_y, rsp_pixel_value, rsp_last};

   `GCB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `GCB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload))
   `GCB_ASSERT_NEXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid ##1 !rsp_valid)
   `GCB_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_ready)
   `GCB_ASSERT_SAME(a_idle_ready, clock, reset, $past(reset) && req_idle, req_ready)

endmodule

bind glyph_coverage_blit_top gcb_checker u_gcb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_dest_x     (rsp_bus.dest_x),
   .rsp_dest_y     (rsp_bus.dest_y),
   .rsp_pixel_value(rsp_bus.pixel_value),
   .rsp_last       (rsp_bus.last)
);

/* tb/tb_glyph_coverage_blit_top.sv */
module tb_glyph_coverage_blit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gcb_pkg::*;

   localparam logic [FMT_W-1:0] FMT_RESERVED = 2'd3;
   localparam int GLYPH_LIMIT   = 256;
   localparam int SURFACE_LIMIT = 4096;
   localparam int DRAIN_CYCLES  = 8;
   localparam int STALL_LIMIT   = 5000;

   typedef struct {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [PIXEL_W-1:0] pixel_value;
      logic               last;
   } blit_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gcb_req_if req_bus();
   gcb_rsp_if rsp_bus();

   glyph_coverage_blit_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // shadow copy of the register file
   logic signed [POS_W-1:0] cur_pos_x;
   logic signed [POS_W-1:0] cur_pos_y;
   logic [GW_REG_W-1:0]     cur_glyph_width;
   logic [DIM_REG_W-1:0]    cur_dest_width;
   logic [DIM_REG_W-1:0]    cur_dest_height;
   logic [PIXEL_W-1:0]      cur_color;
   logic [FMT_W-1:0]        cur_format;
   logic                    cur_index8;

   blit_pixel_type pending_pixels[$];
   int             fail_count;
   int             sent_count;
   int             sender_idle_pct;
   int             receiver_stall_pct;
   int             quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pixels that one source byte places on the surface, in column order.
   function automatic void place_pixels(logic [BYTE_W-1:0] src, logic [BYTE_W-1:0] row,
                                        logic [BYTE_W-1:0] bcol);
      int             px, py, gw, dw, dh, dy, dx, first_col, count, col;
      int unsigned    cov, alpha;
      blit_pixel_type pix;
      blit_pixel_type run[$];
      px = cur_pos_x;
      py = cur_pos_y;
      gw = (cur_glyph_width > GLYPH_LIMIT) ? GLYPH_LIMIT : cur_glyph_width;
      dw = (cur_dest_width > SURFACE_LIMIT) ? SURFACE_LIMIT : cur_dest_width;
      dh = (cur_dest_height > SURFACE_LIMIT) ? SURFACE_LIMIT : cur_dest_height;
      dy = py + int'(row);
      alpha = cur_color[31:24];
      if (dy < 0 || dy >= dh) return;
      if (cur_format == FMT_GRAY) begin
         first_col = bcol;
         count = 1;
      end else if (cur_format == FMT_MONO) begin
         first_col = int'(bcol) * 8;
         count = 8;
      end else begin
         return;
      end
      for (int k = 0; k < count; k++) begin
         col = first_col + k;
         dx = px + col;
         if (col >= gw) break;
         if (dx < 0 || dx >= dw) continue;
         if (cur_format == FMT_GRAY) cov = src;
         else cov = src[7-k] ? 255 : 0;
         if (cov == 0) continue;
         pix.dest_x = dx[COORD_W-1:0];
         pix.dest_y = dy[COORD_W-1:0];
         if (cur_index8) pix.pixel_value = 32'd1;
         else pix.pixel_value = {8'((cov * alpha) / 255), cur_color[23:0]};
         pix.last = 1'b0;
         run.push_back(pix);
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_pixels.push_back(run[i]);
   endfunction

   always @(posedge clock) begin : scoreboard
      blit_pixel_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            place_pixels(req_bus.src_byte, req_bus.glyph_row, req_bus.byte_col);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               $error("unexpected pixel at x %0d y %0d value %h",
                      rsp_bus.dest_x, rsp_bus.dest_y, rsp_bus.pixel_value);
               fail_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_bus.dest_x !== want.dest_x) begin
                  $error("dest_x: expected %0d, actual %0d", want.dest_x, rsp_bus.dest_x);
                  fail_count++;
               end
               if (rsp_bus.dest_y !== want.dest_y) begin
                  $error("dest_y: expected %0d, actual %0d", want.dest_y, rsp_bus.dest_y);
                  fail_count++;
               end
               if (rsp_bus.pixel_value !== want.pixel_value) begin
                  $error("pixel_value: expected %h, actual %h",
                         want.pixel_value, rsp_bus.pixel_value);
                  fail_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_bus.last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles, %0d pixels outstanding",
                quiet_cycles, pending_pixels.size());
         $display("glyph_coverage_blit_top regression: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = (receiver_stall_pct == 0) || ($urandom_range(99, 0) >= receiver_stall_pct);
   end

   // All stimulus tasks start and end just after a falling edge.
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_POS_X:        cur_pos_x = data[POS_W-1:0];
         CSR_POS_Y:        cur_pos_y = data[POS_W-1:0];
         CSR_GLYPH_WIDTH:  cur_glyph_width = data[GW_REG_W-1:0];
         CSR_DEST_WIDTH:   cur_dest_width = data[DIM_REG_W-1:0];
         CSR_DEST_HEIGHT:  cur_dest_height = data[DIM_REG_W-1:0];
         CSR_COLOR_ARGB:   cur_color = data;
         CSR_PIXEL_FORMAT: cur_format = data[FMT_W-1:0];
         CSR_DEST_INDEX8:  cur_index8 = data[0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic wait_idle();
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(int px, int py, int gw, int dw, int dh,
                             logic [31:0] color, logic [FMT_W-1:0] fmt, logic idx8);
      wait_idle();
      write_reg(CSR_POS_X, 32'(px));
      write_reg(CSR_POS_Y, 32'(py));
      write_reg(CSR_GLYPH_WIDTH, 32'(gw));
      write_reg(CSR_DEST_WIDTH, 32'(dw));
      write_reg(CSR_DEST_HEIGHT, 32'(dh));
      write_reg(CSR_COLOR_ARGB, color);
      write_reg(CSR_PIXEL_FORMAT, 32'(fmt));
      write_reg(CSR_DEST_INDEX8, 32'(idx8));
   endtask

   task automatic send_byte(logic [7:0] src, logic [7:0] row, logic [7:0] bcol);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.src_byte = src;
      req_bus.glyph_row = row;
      req_bus.byte_col = bcol;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic test_gray_pixels();
      set_config(10, 20, 256, 4096, 4096, 32'h80112233, FMT_GRAY, 1'b0);
      send_byte(8'h00, 8'd0, 8'd0);
      send_byte(8'hFF, 8'd0, 8'd0);
      send_byte(8'h01, 8'd1, 8'd1);
      send_byte(8'h80, 8'd255, 8'd255);
   endtask

   task automatic test_mono_pixels();
      set_config(0, 0, 256, 4096, 4096, 32'hFFA0B0C0, FMT_MONO, 1'b0);
      send_byte(8'hFF, 8'd0, 8'd0);
      send_byte(8'h00, 8'd0, 8'd1);
      send_byte(8'h81, 8'd2, 8'd3);
      send_byte(8'h01, 8'd3, 8'd31);
      send_byte(8'h80, 8'd4, 8'd32);   // starts past the glyph's right edge
   endtask

   task automatic test_clipping();
      set_config(-4, -2, 20, 12, 6, 32'h7F445566, FMT_MONO, 1'b0);
      send_byte(8'hFF, 8'd0, 8'd0);    // above the surface
      send_byte(8'hFF, 8'd2, 8'd0);    // left half clipped
      send_byte(8'hFF, 8'd2, 8'd1);
      send_byte(8'hFF, 8'd2, 8'd2);    // right of the surface
      send_byte(8'hFF, 8'd7, 8'd0);    // bottom row
      send_byte(8'hFF, 8'd8, 8'd0);    // below the surface
   endtask

   task automatic test_register_extremes();
      // oversized widths clamp to the parameter limits
      set_config(4095, 4095, 511, 8191, 8191, 32'hFFFFFFFF, FMT_GRAY, 1'b0);
      send_byte(8'hFF, 8'd0, 8'd0);
      send_byte(8'hFF, 8'd1, 8'd0);
      set_config(-4096, -4096, 256, 4096, 4096, 32'h00000000, FMT_MONO, 1'b1);
      send_byte(8'hFF, 8'd255, 8'd255);
   endtask

   task automatic test_formats_and_modes();
      set_config(0, 0, 64, 64, 64, 32'h00FFFFFF, FMT_NONE, 1'b0);
      send_byte(8'hFF, 8'd0, 8'd0);
      wait_idle();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_RESERVED));
      send_byte(8'hFF, 8'd0, 8'd0);
      wait_idle();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_GRAY));
      send_byte(8'h7F, 8'd1, 8'd1);    // zero alpha
      wait_idle();
      write_reg(CSR_PIXEL_FORMAT, 32'(FMT_MONO));
      write_reg(CSR_DEST_INDEX8, 32'd1);
      send_byte(8'hAA, 8'd2, 8'd0);
   endtask

   function automatic int pick_offset();
      case ($urandom_range(9, 0))
         0: return -4096;
         1: return 4095;
         2: return $urandom_range(8191, 0) - 4096;
         default: return $urandom_range(80, 0) - 40;
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(9, 0))
         0: return 0;
         1: return 4096;
         2: return $urandom_range(8191, 4097);
         default: return $urandom_range(160, 8);
      endcase
   endfunction

   task automatic randomize_setup();
      int               gw;
      logic [31:0]      color;
      logic [FMT_W-1:0] fmt;
      int               sel;
      case ($urandom_range(9, 0))
         0: gw = 0;
         1: gw = 256;
         2: gw = $urandom_range(511, 257);
         default: gw = $urandom_range(128, 1);
      endcase
      color = $urandom;
      sel = $urandom_range(7, 0);
      if (sel == 0) color[31:24] = 8'h00;
      else if (sel == 1) color[31:24] = 8'hFF;
      sel = $urandom_range(9, 0);
      if (sel < 4) fmt = FMT_GRAY;
      else if (sel < 8) fmt = FMT_MONO;
      else if (sel == 8) fmt = FMT_NONE;
      else fmt = FMT_RESERVED;
      set_config(pick_offset(), pick_offset(), gw, pick_dim(), pick_dim(), color, fmt,
                 ($urandom_range(3, 0) == 0));
   endtask

   // A run of consecutive bytes along one bitmap row.
   task automatic send_row_run();
      int gw_eff, ncols, start, len, row;
      gw_eff = (cur_glyph_width > GLYPH_LIMIT) ? GLYPH_LIMIT : cur_glyph_width;
      ncols = (cur_format == FMT_MONO) ? (gw_eff + 7) / 8 : gw_eff;
      if (ncols == 0) ncols = 1;
      start = $urandom_range(ncols - 1, 0);
      len = $urandom_range(12, 1);
      row = $urandom_range(47, 0);
      for (int j = 0; j < len && start + j < 256; j++)
         send_byte(8'($urandom), 8'(row), 8'(start + j));
   endtask

   task automatic test_random_traffic(int items, int idle_pct, int stall_pct);
      int target;
      int midpoint;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int half = 0; half < 2; half++) begin
         randomize_setup();
         target = sent_count + items / 2;
         midpoint = sent_count + items / 4;
         while (sent_count < target) begin
            if ($urandom_range(99, 0) < 80) send_row_run();
            else send_byte(8'($urandom), 8'($urandom), 8'($urandom));
            if (half == 0 && sent_count >= midpoint && midpoint > 0) begin
               drain_results();   // hold off until the pipeline empties
               midpoint = 0;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.src_byte = '0;
      req_bus.glyph_row = '0;
      req_bus.byte_col = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      fail_count = 0;
      sent_count = 0;
      cur_pos_x = '0;
      cur_pos_y = '0;
      cur_glyph_width = '0;
      cur_dest_width = '0;
      cur_dest_height = '0;
      cur_color = '0;
      cur_format = '0;
      cur_index8 = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_gray_pixels();
      test_mono_pixels();
      test_clipping();
      test_register_extremes();
      test_formats_and_modes();
      test_random_traffic(105, 0, 0);
      test_random_traffic(105, 73, 0);
      test_random_traffic(105, 0, 73);
      test_random_traffic(105, 35, 35);

      sender_idle_pct = 0;
      wait_idle();
      if (fail_count == 0) begin
         $display("glyph_coverage_blit_top regression: pass");
      end else begin
         $display("glyph_coverage_blit_top regression: fail");
      end
      $finish;
   end

endmodule
